FILE: sv/lpe_pkg.sv
// lpe_pkg: shared types, constants and helpers for the line position estimator.
// No dependencies; imported by every module of the block.
package lpe_pkg;

  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned ERR_BITS = 11;
  localparam int unsigned DEF_CHANNELS = 8;

  // position step per channel, sixteenths scale, center step
  localparam int unsigned POS_STEP = 10;
  localparam int unsigned FRAC_SHIFT = 4;
  localparam int unsigned CENTER_STEP = 80;

  // sum of 10*i over all channels is at most 280 at eight channels
  localparam int unsigned POS_W = 7;
  localparam int unsigned SUM_W = 9;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned DVD_W = SUM_W + FRAC_SHIFT;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DCNT_W = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic {
    CMD_CALIBRATE = 1'b0,
    CMD_MEASURE   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic    command;
    sample_t sample_0;
    sample_t sample_1;
    sample_t sample_2;
    sample_t sample_3;
    sample_t sample_4;
    sample_t sample_5;
    sample_t sample_6;
    sample_t sample_7;
  } in_item_t;

  typedef struct packed {
    logic signed [ERR_BITS-1:0] position_error;
    logic                       line_seen;
    logic [MAX_CHANNELS-1:0]    line_pattern;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_calib;
    logic last_ch;
    logic count_zero;
    logic div_last;
    logic out_full;
  } dp_stat_t;

  function automatic sample_t sample_of(input in_item_t d, input int unsigned idx);
    sample_t s;
    case (idx)
      0: s = d.sample_0;
      1: s = d.sample_1;
      2: s = d.sample_2;
      3: s = d.sample_3;
      4: s = d.sample_4;
      5: s = d.sample_5;
      6: s = d.sample_6;
      default: s = d.sample_7;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/lpe_ctrl.sv
// lpe_ctrl: sequencing state machine (accept, channel scan, divide, result hand-off).
// Depends on lpe_pkg; drives lpe_dpath through dp_cmd_t, reads dp_stat_t.
module lpe_ctrl import lpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.last_ch) begin
          state_nxt = stat.is_calib ? ST_IDLE : ST_PREP;
        end
      end
      ST_PREP: begin
        if (stat.count_zero) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/lpe_dpath.sv
// lpe_dpath: calibration levels, per-channel classifier, accumulators,
// radix-2 restoring divider and output register. Depends on lpe_pkg.
module lpe_dpath import lpe_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned CH_W = $clog2(CHANNELS);
  localparam logic [ERR_BITS-1:0] CENTER = ERR_BITS'(CENTER_STEP * (CHANNELS - 1));

  in_item_t                  in_r;
  sample_t                   smp   [CHANNELS];
  sample_t                   low_r [CHANNELS];
  sample_t                   high_r[CHANNELS];
  logic [CH_W-1:0]           ch_r;
  logic [POS_W-1:0]          pos_r;
  logic [SUM_W-1:0]          sum_r;
  logic [CNT_W-1:0]          count_r;
  logic [CHANNELS-1:0]       pattern_r;
  logic [DVD_W-1:0]          dvd_r;
  logic [CNT_W-1:0]          rem_r;
  logic [DCNT_W-1:0]         dcnt_r;
  logic signed [ERR_BITS-1:0] held_error_r;
  logic                      out_valid_r;
  out_item_t                 out_r;

  sample_t          s_cur, lo_cur, hi_cur, d_lo, d_hi;
  logic             is_line;
  logic [CNT_W:0]   trial;
  logic             trial_ge;
  logic [ERR_BITS-1:0] err_new;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      smp[i] = sample_of(in_r, i);
    end
  end

  assign s_cur   = smp[ch_r];
  assign lo_cur  = low_r[ch_r];
  assign hi_cur  = high_r[ch_r];
  assign d_lo    = (lo_cur > s_cur) ? (lo_cur - s_cur) : (s_cur - lo_cur);
  assign d_hi    = (hi_cur > s_cur) ? (hi_cur - s_cur) : (s_cur - hi_cur);
  assign is_line = (d_lo >= d_hi);  // ties count as line

  assign trial    = {rem_r, dvd_r[DVD_W-1]};
  assign trial_ge = (trial >= {1'b0, count_r});
  assign err_new  = ERR_BITS'(dvd_r) - CENTER;

  assign stat.is_calib   = (in_r.command == CMD_CALIBRATE);
  assign stat.last_ch    = (ch_r == CH_W'(CHANNELS - 1));
  assign stat.count_zero = (count_r == '0);
  assign stat.div_last   = (dcnt_r == DCNT_W'(DIV_STEPS - 1));
  assign stat.out_full   = out_valid_r;

  // input capture and divide
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.div_start) begin
      dvd_r <= {sum_r, FRAC_SHIFT'(0)};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial_ge ? CNT_W'(trial - {1'b0, count_r}) : CNT_W'(trial);
      dvd_r <= {dvd_r[DVD_W-2:0], trial_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r      <= '0;
      pos_r     <= '0;
      sum_r     <= '0;
      count_r   <= '0;
      pattern_r <= '0;
      dcnt_r    <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        low_r[i]  <= '1;
        high_r[i] <= '0;
      end
    end else begin
      if (cmd.load_in) begin
        ch_r      <= '0;
        pos_r     <= '0;
        sum_r     <= '0;
        count_r   <= '0;
        pattern_r <= '0;
      end else if (cmd.scan_step) begin
        ch_r  <= stat.last_ch ? '0 : ch_r + 1'b1;
        pos_r <= pos_r + POS_W'(POS_STEP);
        if (stat.is_calib) begin
          if (s_cur < lo_cur) low_r[ch_r]  <= s_cur;
          if (s_cur > hi_cur) high_r[ch_r] <= s_cur;
        end else if (is_line) begin
          pattern_r[ch_r] <= 1'b1;
          count_r         <= count_r + 1'b1;
          sum_r           <= sum_r + SUM_W'(pos_r);
        end
      end
      if (cmd.div_start) begin
        dcnt_r <= '0;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r + 1'b1;
      end
    end
  end

  // held error and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_error_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        if (count_r != '0) held_error_r <= err_new;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.position_error <= (count_r != '0) ? err_new : held_error_r;
      out_r.line_seen      <= (count_r != '0);
      out_r.line_pattern   <= MAX_CHANNELS'(pattern_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid_r)
    else $error("result register loaded while still full");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> count_r != '0)
    else $error("divide step with zero count");

  a_seen_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_r.line_seen == (out_r.line_pattern != '0))
    else $error("line_seen disagrees with pattern");

  a_held_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_r.position_error == held_error_r)
    else $error("result error differs from held error");

endmodule

FILE: sv/line_position_estimator_core.sv
// line_position_estimator_core: top level of the line sensor centroid estimator.
// Depends on lpe_pkg, lpe_ctrl and lpe_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one transaction per sample set,
//   with a command bit and one reading per channel. A calibrate transaction widens
//   each channel's stored min/max and yields no result. A measure transaction
//   classifies each channel (ties toward line) and yields one result transaction.
//   Output channel (out_valid / out_stall / out_data): position error in
//   sixteenths, line_seen and the per-channel line pattern. With no channel on
//   the line, the previous error is repeated and line_seen is 0.
// Timing:
//   One item in flight. After acceptance the controller scans CHANNELS channels,
//   one per cycle (the shared classifier), then a radix-2 restoring divider yields
//   one quotient bit per cycle. A calibrate item ends after the scan; a measure
//   item with no line seen skips the divider. The result is loaded into the
//   output register from the output state once that register is empty.
//   The result sits in an output register, so the next item is accepted while it
//   waits; a stalled receiver only holds back the following result.
// Reset (rst_n low, synchronous): min levels to all ones, max levels to zero,
//   held error to zero, no result pending, ready for input next cycle.
module line_position_estimator_core import lpe_pkg::*; #(
  parameter int unsigned CHANNELS = DEF_CHANNELS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: owns the handshake on the input side
  lpe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: levels, classifier, divider, result register
  lpe_dpath #(
    .CHANNELS (CHANNELS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: bench/tb_line_position_estimator_core.sv
// Self-checking testbench for line_position_estimator_core: directed and random sample sets,
// random idling on both channels, and a scoreboard class that predicts every estimate.
// Depends on lpe_pkg and the core RTL only.
module tb_line_position_estimator_core import lpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Tracks the per-channel calibration levels and the held error. It predicts the estimate
  // for every measure transaction and checks results in order against those predictions.
  class centroid_tracker;
    sample_t                    low_lvl[MAX_CHANNELS];
    sample_t                    high_lvl[MAX_CHANNELS];
    logic signed [ERR_BITS-1:0] held_err;
    out_item_t                  pending_estimates[$];
    int                         mismatches;

    function new();
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        low_lvl[i]  = '1;
        high_lvl[i] = '0;
      end
      held_err   = '0;
      mismatches = 0;
    endfunction

    // Note one accepted sample set; queue an estimate for a measure.
    function void take_sample_set(in_item_t d);
      sample_t   rd[MAX_CHANNELS];
      logic [MAX_CHANNELS-1:0] pattern;
      int        hits;
      int        pos_sum;
      int        to_low;
      int        to_high;
      int        err;
      out_item_t est;
      rd = '{d.sample_0, d.sample_1, d.sample_2, d.sample_3,
             d.sample_4, d.sample_5, d.sample_6, d.sample_7};
      if (d.command == CMD_CALIBRATE) begin
        for (int i = 0; i < DEF_CHANNELS; i++) begin
          if (rd[i] < low_lvl[i]) low_lvl[i] = rd[i];
          if (rd[i] > high_lvl[i]) high_lvl[i] = rd[i];
        end
        return;
      end
      pattern = '0;
      hits    = 0;
      pos_sum = 0;
      for (int i = 0; i < DEF_CHANNELS; i++) begin
        to_low  = int'(low_lvl[i]) - int'(rd[i]);
        to_high = int'(high_lvl[i]) - int'(rd[i]);
        if (to_low < 0) to_low = -to_low;
        if (to_high < 0) to_high = -to_high;
        // ties go to line
        if (to_low >= to_high) begin
          pattern[i] = 1'b1;
          hits++;
          pos_sum += int'(POS_STEP) * i;
        end
      end
      if (hits != 0) begin
        err = (16 * pos_sum) / hits - int'(CENTER_STEP) * (int'(DEF_CHANNELS) - 1);
        held_err = ERR_BITS'(err);
      end
      est.position_error = held_err;
      est.line_seen      = (hits != 0);
      est.line_pattern   = pattern;
      pending_estimates.push_back(est);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_estimate(out_item_t got);
      out_item_t est;
      if (pending_estimates.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: err %0d seen %0b pat %02h",
                                  int'(got.position_error), got.line_seen, got.line_pattern));
        return;
      end
      est = pending_estimates.pop_front();
      if (got.position_error !== est.position_error)
        report_mismatch($sformatf("position_error got %0d, want %0d",
                                  int'(got.position_error), int'(est.position_error)));
      if (got.line_seen !== est.line_seen)
        report_mismatch($sformatf("line_seen got %0b, want %0b", got.line_seen, est.line_seen));
      if (got.line_pattern !== est.line_pattern)
        report_mismatch($sformatf("line_pattern got %02h, want %02h",
                                  got.line_pattern, est.line_pattern));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  centroid_tracker tracker = new();

  // sender idles only when set; cleared for gap-free stretches
  bit gaps_on = 1'b1;
  // sender raises this to have the receiver hold off for a long stretch
  bit squeeze_req = 1'b0;

  always #5 clk = ~clk;

  line_position_estimator_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Observe both channels at the rising edge; inputs only move at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.take_sample_set(in_data);
      if (out_valid && !out_stall) tracker.check_estimate(out_data);
    end
  end

  function automatic in_item_t pack_set(cmd_e cmd, sample_t r[MAX_CHANNELS]);
    in_item_t it;
    it.command  = cmd;
    it.sample_0 = r[0];
    it.sample_1 = r[1];
    it.sample_2 = r[2];
    it.sample_3 = r[3];
    it.sample_4 = r[4];
    it.sample_5 = r[5];
    it.sample_6 = r[6];
    it.sample_7 = r[7];
    return it;
  endfunction

  // Idle gap before a transaction: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transaction and hold it steady until the core takes it.
  task automatic offer_set(in_item_t it);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // Channels whose mask bit is set get on_val, the rest off_val.
  task automatic offer_mask(cmd_e cmd, logic [MAX_CHANNELS-1:0] mask,
                            sample_t on_val, sample_t off_val);
    sample_t r[MAX_CHANNELS];
    for (int i = 0; i < MAX_CHANNELS; i++) r[i] = mask[i] ? on_val : off_val;
    offer_set(pack_set(cmd, r));
  endtask

  task automatic run_directed();
    // Uncalibrated levels (min all ones, max zero): anything up to 511 reads as line.
    offer_mask(CMD_MEASURE, 8'hFF, 10'd0, 10'd0);        // every channel, centered
    offer_mask(CMD_MEASURE, 8'hFF, 10'd1023, 10'd1023);  // nothing seen, held zero
    offer_mask(CMD_MEASURE, 8'h01, 10'd0, 10'd1023);     // far left
    offer_mask(CMD_MEASURE, 8'h80, 10'd0, 10'd1023);     // far right
    offer_mask(CMD_MEASURE, 8'hFF, 10'd1023, 10'd1023);  // held far-right error
    offer_mask(CMD_MEASURE, 8'h55, 10'd511, 10'd512);    // just either side of midpoint
    offer_mask(CMD_MEASURE, 8'h0B, 10'd0, 10'd1023);     // centroid with a remainder
    offer_mask(CMD_MEASURE, 8'h55, 10'h155, 10'h2AA);    // alternating bits
    offer_mask(CMD_MEASURE, 8'hAA, 10'h155, 10'h2AA);
    // Widen even channels down to zero and odd channels up to full scale.
    offer_mask(CMD_CALIBRATE, 8'h55, 10'd0, 10'd1023);
    offer_mask(CMD_CALIBRATE, 8'hFF, 10'd600, 10'd600);
    offer_mask(CMD_MEASURE, 8'hFF, 10'd300, 10'd300);    // exact tie on even channels
    offer_mask(CMD_MEASURE, 8'hFF, 10'd811, 10'd811);    // odd channels just short
    offer_mask(CMD_MEASURE, 8'hFF, 10'd812, 10'd812);    // odd channels just over
    offer_mask(CMD_CALIBRATE, 8'hFF, 10'd400, 10'd400);
    offer_mask(CMD_MEASURE, 8'hFF, 10'd1023, 10'd1023);
    offer_mask(CMD_MEASURE, 8'hFF, 10'd0, 10'd0);        // nothing seen after calibration
    offer_mask(CMD_MEASURE, 8'h3C, 10'd1023, 10'd0);
  endtask

  // Random sample for a measure, biased toward the current decision boundary.
  function automatic sample_t measure_sample(int ch);
    int lo;
    int hi;
    int s;
    lo = int'(tracker.low_lvl[ch]);
    hi = int'(tracker.high_lvl[ch]);
    case ($urandom_range(0, 7))
      0, 1:    s = $urandom_range(0, 1023);
      2:       s = 0;
      3:       s = 1023;
      4, 5:    s = (lo + hi) / 2 + $urandom_range(0, 2) - 1;
      6:       s = lo + $urandom_range(0, 3);
      default: s = hi - $urandom_range(0, 3);
    endcase
    if (s < 0) s = 0;
    if (s > 1023) s = 1023;
    return sample_t'(s);
  endfunction

  task automatic run_random(int n_sets);
    sample_t r[MAX_CHANNELS];
    int      span;
    int      lo;
    int      hi;
    bit      dark;
    for (int k = 0; k < n_sets; k++) begin
      // a gap-free stretch every third block of forty
      gaps_on = ((k / 40) % 3 != 1);
      if (k == 60) squeeze_req = 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        // calibration band opens up slowly so the levels keep moving
        span = 40 + 2 * k;
        lo = (span > 512) ? 0 : 512 - span;
        hi = (511 + span > 1023) ? 1023 : 511 + span;
        for (int i = 0; i < MAX_CHANNELS; i++)
          r[i] = ($urandom_range(0, 9) == 0) ? sample_t'($urandom_range(0, 1023))
                                             : sample_t'($urandom_range(lo, hi));
        offer_set(pack_set(CMD_CALIBRATE, r));
      end else begin
        // some sets sit at the minimum everywhere, so no line is seen
        dark = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < MAX_CHANNELS; i++)
          r[i] = dark ? tracker.low_lvl[i] : measure_sample(i);
        offer_set(pack_set(CMD_MEASURE, r));
      end
    end
  endtask

  // Receiver: random stall runs, free-flowing stretches, and one long hold-off on request.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = 300;
        while (hold > 0) begin
          @(negedge clk);
          out_stall <= 1'b1;
          hold--;
        end
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
          6, 7: begin
            repeat ($urandom_range(1, 3)) begin
              @(negedge clk);
              out_stall <= 1'b1;
            end
          end
          8: begin
            repeat ($urandom_range(10, 40)) begin
              @(negedge clk);
              out_stall <= 1'b1;
            end
          end
          default: begin
            repeat ($urandom_range(30, 80)) begin
              @(negedge clk);
              out_stall <= 1'b0;
            end
          end
        endcase
      end
    end
  end

  // Main sequence: reset, directed sets, random sets, drain, verdict.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random(450);
    @(negedge clk);
    in_valid <= 1'b0;
    // wait for every predicted estimate, then give stray results time to show up
    while (tracker.pending_estimates.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("line_position_estimator_core verification clean");
    end else begin
      $display("line_position_estimator_core verification failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("line_position_estimator_core verification failed");
    $finish;
  end

endmodule
